// File: rtl/core/jlsi_pkg.sv
// Shared constants and types of the leveled JSON structural index.
// Used by the channel interfaces and by the top level; depends on nothing.
`default_nettype none

package jlsi_pkg;

   // Word geometry.
   localparam int WORD_BYTES = 64;
   localparam int WORD_BITS  = WORD_BYTES * 8;
   localparam int RESULT_CAP = 32;

   // Byte codes of the character classes.
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_COLON     = 8'h3a;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7b;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7d;
   localparam logic [7:0] CHAR_COMMA     = 8'h2c;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5b;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5d;

   typedef logic [63:0] bitmap_type;

   // Register index, taken from address bits 3:2.
   typedef enum logic [1:0] {
      CSR_MAX_DEPTH       = 2'd0,
      CSR_FIRST_CHUNK     = 2'd1,
      CSR_START_IN_STRING = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

// File: rtl/core/jlsi_req_if.sv
// Input channel of the leveled JSON structural index: one 64-byte word per item.
// Depends on jlsi_pkg.
`default_nettype none

interface jlsi_req_if;
   import jlsi_pkg::*;

   logic       valid;
   logic       ready;
   bitmap_type bytes_0_7;
   bitmap_type bytes_8_15;
   bitmap_type bytes_16_23;
   bitmap_type bytes_24_31;
   bitmap_type bytes_32_39;
   bitmap_type bytes_40_47;
   bitmap_type bytes_48_55;
   bitmap_type bytes_56_63;
   logic       last_word;

   modport source (
      output valid, bytes_0_7, bytes_8_15, bytes_16_23, bytes_24_31,
             bytes_32_39, bytes_40_47, bytes_48_55, bytes_56_63, last_word,
      input  ready
   );
   modport sink (
      input  valid, bytes_0_7, bytes_8_15, bytes_16_23, bytes_24_31,
             bytes_32_39, bytes_40_47, bytes_48_55, bytes_56_63, last_word,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/jlsi_rsp_if.sv
// Result channel of the leveled JSON structural index: one level record per item.
// Depends on jlsi_pkg.
`default_nettype none

interface jlsi_rsp_if;
   import jlsi_pkg::*;

   logic              valid;
   logic              ready;
   logic signed [4:0] level;
   bitmap_type        colon_bits;
   bitmap_type        comma_bits;
   bitmap_type        quote_mask;
   bitmap_type        string_bits;
   logic              last_of_word;
   logic signed [5:0] final_level;
   logic [4:0]        max_level_seen;
   logic signed [4:0] min_level_seen;
   logic              ends_in_string;

   modport source (
      output valid, level, colon_bits, comma_bits, quote_mask, string_bits,
             last_of_word, final_level, max_level_seen, min_level_seen, ends_in_string,
      input  ready
   );
   modport sink (
      input  valid, level, colon_bits, comma_bits, quote_mask, string_bits,
             last_of_word, final_level, max_level_seen, min_level_seen, ends_in_string,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/json_leveled_structural_index_top.sv
// Top level of the leveled JSON structural index.
// Depends on jlsi_pkg, jlsi_req_if and jlsi_rsp_if.
`default_nettype none

// A word is taken only when the block is idle. Its 64 bytes are then walked one
// byte per cycle through a shift register, followed by a flush step that closes
// the last segment. The per-level bitmaps sit in a memory of 2*LEVEL_COUNT
// entries; the report then scans that memory in level order and sends the touched
// levels as records, waiting while the result side stalls. Escape parity,
// in-string state and the nesting level carry from word to word until a word
// marked last_word.
module json_leveled_structural_index_top #(
   parameter int LEVEL_COUNT = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   jlsi_req_if.sink         req_chan,
   jlsi_rsp_if.source       rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import jlsi_pkg::*;

   localparam int SLOTS = 2 * LEVEL_COUNT;
   localparam int IW    = $clog2(SLOTS);
   localparam int LW    = $clog2(LEVEL_COUNT + 1) + 1;
   localparam int HW    = $clog2(LEVEL_COUNT + 1);
   localparam logic signed [LW-1:0] LV_TOP  = LW'(LEVEL_COUNT);
   localparam logic signed [LW-1:0] LV_BOT  = LW'(-LEVEL_COUNT);
   localparam logic signed [LW-1:0] LV_INIT = LW'(-1);
   localparam logic signed [7:0]    LV_MIN8 = 8'(-LEVEL_COUNT);

   typedef enum logic [2:0] {
      S_IDLE, S_WALK, S_FLUSH, S_SCAN, S_EMIT, S_NONE
   } state_type;

   // Configuration registers.
   logic [3:0] max_depth_ff;
   logic       first_chunk_ff;
   logic       start_in_string_ff;

   // Walk state.
   state_type             state_ff;
   logic [WORD_BITS-1:0]  data_ff;
   logic                  last_word_ff;
   logic [5:0]            byte_ff;
   bitmap_type            pos_ff;
   logic                  bs_odd_ff;
   logic                  str_ff;
   logic                  chunk_start_ff;
   logic signed [LW-1:0]  cur_ff;
   logic [HW-1:0]         hi_ff;
   logic signed [LW-1:0]  lo_ff;
   bitmap_type            seg_colon_ff;
   bitmap_type            seg_comma_ff;
   bitmap_type            seg_mark_ff;
   bitmap_type            quote_ff;
   bitmap_type            string_ff;
   logic [SLOTS-1:0]      touched_ff;
   logic                  hit_ff;
   logic [127:0]          rd_ff;
   logic [IW-1:0]         ptr_ff;
   logic [4:0]            emit_cnt_ff;

   // Word totals, held for the report.
   logic signed [LW-1:0]  fin_level_ff;
   logic [HW-1:0]         fin_hi_ff;
   logic signed [LW-1:0]  fin_lo_ff;
   logic                  fin_str_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic signed [4:0]     rsp_level_ff;
   bitmap_type            rsp_colon_ff;
   bitmap_type            rsp_comma_ff;
   bitmap_type            rsp_quote_ff;
   bitmap_type            rsp_string_ff;
   logic                  rsp_last_ff;
   logic signed [5:0]     rsp_final_ff;
   logic [4:0]            rsp_max_ff;
   logic signed [4:0]     rsp_min_ff;
   logic                  rsp_ends_ff;

   // Level accumulator memory: comma bitmap in the upper half, colon in the lower.
   logic [127:0]          acc_mem [SLOTS];

   // A level is recorded from -LEVEL_COUNT up to the depth limit.
   function automatic logic is_rec(logic signed [LW-1:0] lv, logic [3:0] md);
      logic signed [7:0] lv8;
      logic signed [7:0] lim8;
      lv8  = 8'(lv);
      lim8 = (8'(md) < 8'(LEVEL_COUNT - 1)) ? 8'(md) : 8'(LEVEL_COUNT - 1);
      return (lv8 >= LV_MIN8) && (lv8 <= lim8);
   endfunction

   // Memory entries are kept in level order, lowest level at entry zero.
   function automatic logic [IW-1:0] slot_of(logic signed [LW-1:0] lv);
      logic [7:0] s;
      s = 8'(lv) + 8'(LEVEL_COUNT);
      return s[IW-1:0];
   endfunction

   // Byte decode and the per-byte scan logic.
   logic [7:0]           cur_byte;
   logic                 is_quote, quote_valid, bs_odd_in, str_in, outside;
   logic                 is_colon, is_comma, is_open, is_close;
   logic                 walking, bracket, seg_end, seg_has;
   bitmap_type           close_bit, old_colon, old_comma;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [127:0]         wr_data;
   logic signed [LW-1:0] cur_in;
   logic [IW-1:0]        rd_addr;
   logic                 hit_in;
   logic [SLOTS-1:0]     above;
   logic                 rsp_free, emit_last;
   logic                 rsp_valid_in;
   logic [7:0]           ptr_level;

   always_comb begin
      cur_byte    = data_ff[7:0];
      walking     = (state_ff == S_WALK);
      is_quote    = (cur_byte == CHAR_QUOTE);
      quote_valid = is_quote & ~bs_odd_ff;
      bs_odd_in   = (cur_byte == CHAR_BACKSLASH) & ~bs_odd_ff;
      str_in      = str_ff ^ quote_valid;
      outside     = ~str_in;
      is_colon    = (cur_byte == CHAR_COLON) & outside;
      is_comma    = (cur_byte == CHAR_COMMA) & outside;
      is_open     = ((cur_byte == CHAR_LBRACE) | (cur_byte == CHAR_LBRACKET)) & outside;
      is_close    = ((cur_byte == CHAR_RBRACE) | (cur_byte == CHAR_RBRACKET)) & outside;
      bracket     = walking & (is_open | is_close);
      seg_end     = bracket | (state_ff == S_FLUSH);
      seg_has     = |seg_colon_ff;
      close_bit   = (walking & is_close) ? pos_ff : '0;
      old_colon   = hit_ff ? rd_ff[63:0] : '0;
      old_comma   = hit_ff ? rd_ff[127:64] : '0;

      // A finished segment gives its colons if it has any, else its commas.
      wr_data[63:0]   = old_colon | (seg_has ? seg_colon_ff : '0) | close_bit;
      wr_data[127:64] = old_comma | (seg_has ? '0 : seg_comma_ff) | seg_mark_ff | close_bit;
      wr_en           = seg_end & is_rec(cur_ff, max_depth_ff);
      wr_addr         = slot_of(cur_ff);

      // Level after this byte, saturating at both bounds.
      cur_in = cur_ff;
      if (bracket) begin
         if (is_open) begin
            if (cur_ff < LV_TOP) cur_in = cur_ff + LW'(1);
         end else begin
            if (cur_ff > LV_BOT) cur_in = cur_ff - LW'(1);
         end
      end

      // The memory is read at the next segment's level, or at the scan pointer.
      if (state_ff == S_SCAN || state_ff == S_EMIT || state_ff == S_NONE) begin
         rd_addr = ptr_ff;
      end else begin
         rd_addr = slot_of(cur_in);
      end
      hit_in = (state_ff != S_IDLE) && is_rec(cur_in, max_depth_ff) &&
               (touched_ff[rd_addr] || (wr_en && wr_addr == rd_addr));

      // Touched levels above the scan pointer and the record cap decide the last record.
      for (int i = 0; i < SLOTS; i++) begin
         above[i] = touched_ff[i] && (i > int'(ptr_ff));
      end
      emit_last = ~(|above) || (emit_cnt_ff == 5'(RESULT_CAP - 1));
      rsp_free  = ~rsp_valid_ff | rsp_chan.ready;
      // The result register fills when a record is sent and empties when it is taken.
      rsp_valid_in = (((state_ff == S_EMIT) || (state_ff == S_NONE)) && rsp_free) ||
                     (rsp_valid_ff && !rsp_chan.ready);
      ptr_level = 8'(ptr_ff) - 8'(LEVEL_COUNT);
   end

   // Accumulator memory with a registered read; a same-cycle write is forwarded.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         acc_mem[wr_addr] <= wr_data;
      end
      if (wr_en && wr_addr == rd_addr) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= acc_mem[rd_addr];
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_depth_ff       <= 4'd15;
         first_chunk_ff     <= 1'b1;
         start_in_string_ff <= 1'b0;
      end else if (psel && penable && pwrite) begin
         unique case (csr_index_type'(paddr[3:2]))
            CSR_MAX_DEPTH:       max_depth_ff       <= pwdata[3:0];
            CSR_FIRST_CHUNK:     first_chunk_ff     <= pwdata[0];
            CSR_START_IN_STRING: start_in_string_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Configuration reads.
   always_comb begin
      pready = 1'b1;
      unique case (csr_index_type'(paddr[3:2]))
         CSR_MAX_DEPTH:       prdata = {28'd0, max_depth_ff};
         CSR_FIRST_CHUNK:     prdata = {31'd0, first_chunk_ff};
         CSR_START_IN_STRING: prdata = {31'd0, start_in_string_ff};
         default:             prdata = 32'd0;
      endcase
   end

   // Sequencer: load, byte walk, final segment, level scan and report.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         bs_odd_ff      <= 1'b0;
         str_ff         <= 1'b0;
         chunk_start_ff <= 1'b1;
         cur_ff         <= LV_INIT;
         hi_ff          <= '0;
         lo_ff          <= LV_INIT;
         touched_ff     <= '0;
         hit_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         ptr_ff         <= '0;
         emit_cnt_ff    <= '0;
      end else begin
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  data_ff <= {req_chan.bytes_56_63, req_chan.bytes_48_55,
                              req_chan.bytes_40_47, req_chan.bytes_32_39,
                              req_chan.bytes_24_31, req_chan.bytes_16_23,
                              req_chan.bytes_8_15, req_chan.bytes_0_7};
                  last_word_ff <= req_chan.last_word;
                  byte_ff      <= '0;
                  pos_ff       <= 64'd1;
                  seg_colon_ff <= '0;
                  seg_comma_ff <= '0;
                  seg_mark_ff  <= '0;
                  touched_ff   <= '0;
                  if (chunk_start_ff) begin
                     bs_odd_ff      <= 1'b0;
                     str_ff         <= start_in_string_ff;
                     chunk_start_ff <= 1'b0;
                  end
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               data_ff   <= data_ff >> 8;
               pos_ff    <= pos_ff << 1;
               byte_ff   <= byte_ff + 6'd1;
               bs_odd_ff <= bs_odd_in;
               str_ff    <= str_in;
               quote_ff  <= {quote_valid, quote_ff[63:1]};
               string_ff <= {str_in, string_ff[63:1]};
               if (wr_en) begin
                  touched_ff[wr_addr] <= 1'b1;
               end
               if (bracket) begin
                  // A new segment starts; an opening bracket marks the next level.
                  seg_colon_ff <= '0;
                  seg_comma_ff <= '0;
                  seg_mark_ff  <= is_open ? pos_ff : '0;
               end else begin
                  seg_colon_ff <= seg_colon_ff | (is_colon ? pos_ff : '0);
                  seg_comma_ff <= seg_comma_ff | (is_comma ? pos_ff : '0);
               end
               cur_ff <= cur_in;
               if (8'(cur_in) > $signed(8'(hi_ff))) begin
                  hi_ff <= HW'(cur_in);
               end
               if (cur_in < lo_ff) begin
                  lo_ff <= cur_in;
               end
               if (byte_ff == 6'd63) begin
                  state_ff <= S_FLUSH;
               end
            end
            S_FLUSH: begin
               if (wr_en) begin
                  touched_ff[wr_addr] <= 1'b1;
               end
               fin_level_ff <= cur_ff;
               fin_hi_ff    <= hi_ff;
               fin_lo_ff    <= lo_ff;
               fin_str_ff   <= str_ff;
               // The end of a chunk returns the levels to their start values.
               if (last_word_ff) begin
                  cur_ff         <= LV_INIT;
                  hi_ff          <= '0;
                  lo_ff          <= LV_INIT;
                  chunk_start_ff <= 1'b1;
               end
               ptr_ff      <= '0;
               emit_cnt_ff <= '0;
               state_ff    <= S_SCAN;
            end
            S_SCAN: begin
               if (touched_ff[ptr_ff]) begin
                  state_ff <= S_EMIT;
               end else if (ptr_ff == IW'(SLOTS - 1)) begin
                  state_ff <= S_NONE;
               end else begin
                  ptr_ff <= ptr_ff + IW'(1);
               end
            end
            S_EMIT: begin
               if (rsp_free) begin
                  rsp_level_ff  <= ptr_level[4:0];
                  rsp_colon_ff  <= rd_ff[63:0];
                  rsp_comma_ff  <= rd_ff[127:64];
                  rsp_quote_ff  <= quote_ff;
                  rsp_string_ff <= string_ff;
                  rsp_last_ff   <= emit_last;
                  rsp_final_ff  <= 6'(fin_level_ff);
                  rsp_max_ff    <= 5'(fin_hi_ff);
                  rsp_min_ff    <= 5'(fin_lo_ff);
                  rsp_ends_ff   <= fin_str_ff;
                  if (emit_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     ptr_ff      <= ptr_ff + IW'(1);
                     emit_cnt_ff <= emit_cnt_ff + 5'd1;
                     state_ff    <= S_SCAN;
                  end
               end
            end
            S_NONE: begin
               // No level was touched: one empty record at level zero.
               if (rsp_free) begin
                  rsp_level_ff  <= '0;
                  rsp_colon_ff  <= '0;
                  rsp_comma_ff  <= '0;
                  rsp_quote_ff  <= quote_ff;
                  rsp_string_ff <= string_ff;
                  rsp_last_ff   <= 1'b1;
                  rsp_final_ff  <= 6'(fin_level_ff);
                  rsp_max_ff    <= 5'(fin_hi_ff);
                  rsp_min_ff    <= 5'(fin_lo_ff);
                  rsp_ends_ff   <= fin_str_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Channel outputs.
   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.level          = rsp_level_ff;
   assign rsp_chan.colon_bits     = rsp_colon_ff;
   assign rsp_chan.comma_bits     = rsp_comma_ff;
   assign rsp_chan.quote_mask     = rsp_quote_ff;
   assign rsp_chan.string_bits    = rsp_string_ff;
   assign rsp_chan.last_of_word   = rsp_last_ff;
   assign rsp_chan.final_level    = rsp_final_ff;
   assign rsp_chan.max_level_seen = rsp_max_ff;
   assign rsp_chan.min_level_seen = rsp_min_ff;
   assign rsp_chan.ends_in_string = rsp_ends_ff;

endmodule

`default_nettype wire
